/* rtl/chunk_token_encoder_core_assert.svh */
// Assertion macros used by the checker file of the token encoder.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CHUNK_TOKEN_ENCODER_CORE_ASSERT_SVH
`define CHUNK_TOKEN_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define CTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define CTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cte_pkg.sv */
// Package for the token encoder: payload structs, codes and state types.
// No dependencies.
`timescale 1ns / 1ps

package cte_pkg;

  // Token kind codes carried in the func field.
  localparam logic [1:0] FUNC_TEXT   = 2'd0;
  localparam logic [1:0] FUNC_NUMBER = 2'd1;

  // Symbols used by number tokens.
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [3:0] DIGIT_HI  = 4'h3;

  // Reciprocal of ten, scaled by 2^35, for the quotient of a 32-bit value.
  localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         char_code;
    logic signed [31:0] number_value;
    logic [7:0]         end_code;
    logic               append_end;
  } tok_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HI,
    ST_LO,
    ST_DIV,
    ST_DIGIT
  } cte_state_t;

  typedef enum logic [1:0] {
    K_CHAR,
    K_SIGN,
    K_DIGIT,
    K_END
  } cte_kind_t;

  // High nibble goes to bits 6..3, bits 7 and 2 are always set.
  function automatic logic [7:0] enc_hi(input logic [7:0] sym);
    return {1'b1, sym[7:4], 3'b100};
  endfunction

  function automatic logic [7:0] enc_lo(input logic [7:0] sym);
    return {1'b1, sym[3:0], 3'b100};
  endfunction

endpackage

/* rtl/chunk_token_encoder_core.sv */
// Rate: one token is taken while idle; each encoded symbol leaves as two words, one per cycle
// while the output is not stalled. Text token: 2 or 4 words; end-only token: 2 words; number
// token: 2 + 2 per digit + 2 words, using the shared divide-by-ten multiplier once per digit.
// The block is ready again at the edge that loads the last word into the output register.
// After accept the token is registered and the high-nibble state loads the first word once
// the output is free. Reset (rst, synchronous) returns to idle and empties the output register.
// Depends on cte_pkg.
`timescale 1ns / 1ps

module chunk_token_encoder_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            tok_valid,
  output logic            tok_stall,
  input  cte_pkg::tok_t   tok,
  output logic            word_valid,
  input  logic            word_stall,
  output cte_pkg::word_t  word
);

  // Control registers.
  cte_pkg::cte_state_t state, state_next;
  logic                out_valid, out_valid_next;

  // Datapath registers.
  cte_pkg::cte_kind_t  kind, kind_next;
  logic [7:0]          sym, sym_next;
  logic [7:0]          endc, endc_next;
  logic                app, app_next;
  logic [31:0]         mag, mag_next;
  logic [31:0]         quo, quo_next;
  cte_pkg::word_t      out_word, out_word_next;

  // Shared divide-by-ten unit: multiply, then remainder from the registered quotient.
  logic [63:0] prod;
  logic [31:0] quo10;
  logic [31:0] rem;
  logic        out_free;
  logic        accept;
  logic        neg;

  assign prod  = {32'b0, mag} * {32'b0, cte_pkg::RECIP_TEN};
  assign quo10 = {quo[28:0], 3'b000} + {quo[30:0], 1'b0};
  assign rem   = mag - quo10;

  assign out_free  = !out_valid || !word_stall;
  assign tok_stall = (state != cte_pkg::ST_IDLE);
  assign accept    = tok_valid && !tok_stall;
  assign neg       = tok.number_value[31];

  assign word_valid = out_valid;
  assign word       = out_word;

  // Sequencer: next state, datapath updates and output loads.
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && word_stall;
    kind_next      = kind;
    sym_next       = sym;
    endc_next      = endc;
    app_next       = app;
    mag_next       = mag;
    quo_next       = quo;
    out_word_next  = out_word;

    case (state)
      cte_pkg::ST_IDLE: begin
        if (accept) begin
          endc_next  = tok.end_code;
          app_next   = tok.append_end;
          mag_next   = neg ? (32'd0 - tok.number_value) : tok.number_value;
          state_next = cte_pkg::ST_HI;
          if (tok.func == cte_pkg::FUNC_TEXT) begin
            kind_next = cte_pkg::K_CHAR;
            sym_next  = tok.char_code;
          end else if (tok.func == cte_pkg::FUNC_NUMBER) begin
            kind_next = cte_pkg::K_SIGN;
            sym_next  = neg ? cte_pkg::SYM_MINUS : cte_pkg::SYM_PLUS;
          end else begin
            kind_next = cte_pkg::K_END;
            sym_next  = tok.end_code;
          end
        end
      end

      cte_pkg::ST_HI: begin
        if (out_free) begin
          out_valid_next            = 1'b1;
          out_word_next.out_byte    = cte_pkg::enc_hi(sym);
          out_word_next.last_of_run = 1'b0;
          state_next                = cte_pkg::ST_LO;
        end
      end

      cte_pkg::ST_LO: begin
        if (out_free) begin
          out_valid_next            = 1'b1;
          out_word_next.out_byte    = cte_pkg::enc_lo(sym);
          out_word_next.last_of_run = (kind == cte_pkg::K_END) ||
                                      (kind == cte_pkg::K_CHAR && !app);
          case (kind)
            cte_pkg::K_CHAR: begin
              if (app) begin
                kind_next  = cte_pkg::K_END;
                sym_next   = endc;
                state_next = cte_pkg::ST_HI;
              end else begin
                state_next = cte_pkg::ST_IDLE;
              end
            end
            cte_pkg::K_SIGN: begin
              state_next = cte_pkg::ST_DIV;
            end
            cte_pkg::K_DIGIT: begin
              if (mag != 32'd0) begin
                state_next = cte_pkg::ST_DIV;
              end else begin
                kind_next  = cte_pkg::K_END;
                sym_next   = endc;
                state_next = cte_pkg::ST_HI;
              end
            end
            default: begin
              state_next = cte_pkg::ST_IDLE;
            end
          endcase
        end
      end

      // Quotient of the magnitude by ten, registered before the remainder step.
      cte_pkg::ST_DIV: begin
        quo_next   = {3'b000, prod[63:cte_pkg::RECIP_SHIFT]};
        state_next = cte_pkg::ST_DIGIT;
      end

      // Least significant digit becomes the next symbol; the quotient carries on.
      cte_pkg::ST_DIGIT: begin
        kind_next  = cte_pkg::K_DIGIT;
        sym_next   = {cte_pkg::DIGIT_HI, rem[3:0]};
        mag_next   = quo;
        state_next = cte_pkg::ST_HI;
      end

      default: begin
        state_next = cte_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cte_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    kind     <= kind_next;
    sym      <= sym_next;
    endc     <= endc_next;
    app      <= app_next;
    mag      <= mag_next;
    quo      <= quo_next;
    out_word <= out_word_next;
  end

endmodule

/* rtl/cte_checker.sv */
// Port-level checks for the token encoder, attached to the top level by bind.
// Depends on cte_pkg and chunk_token_encoder_core_assert.svh.
`timescale 1ns / 1ps
`include "chunk_token_encoder_core_assert.svh"

module cte_checker (
  input logic           clk,
  input logic           rst,
  input logic           tok_valid,
  input logic           tok_stall,
  input logic           word_valid,
  input logic           word_stall,
  input cte_pkg::word_t word
);

  // Port conditions that the checks below refer to.
  logic fmt_ok;
  logic word_held;
  logic tok_take;
  logic idle_wait;

  assign fmt_ok    = word.out_byte[7] && word.out_byte[2] && (word.out_byte[1:0] == 2'b00);
  assign word_held = word_valid && word_stall;
  assign tok_take  = tok_valid && !tok_stall;
  assign idle_wait = !tok_stall && word_valid;

  // Every word carries the fixed marker bits and clear low bits.
  `CTE_ASSERT_NOW(a_word_format, word_valid, fmt_ok, "word lacks fixed bits")

  // A held word stays put until it is taken.
  `CTE_ASSERT_NEXT(a_word_hold, word_held, word_valid && $stable(word), "stalled word changed")

  // After taking a token the block is busy encoding it.
  `CTE_ASSERT_NEXT(a_busy_after_accept, tok_take, tok_stall, "ready right after accept")

  // When ready for a token, any word still waiting is the final word of the previous run.
  `CTE_ASSERT_NOW(a_idle_last, idle_wait, word.last_of_run, "idle with an unfinished run")

endmodule

bind chunk_token_encoder_core cte_checker u_cte_checker (
  .clk        (clk),
  .rst        (rst),
  .tok_valid  (tok_valid),
  .tok_stall  (tok_stall),
  .word_valid (word_valid),
  .word_stall (word_stall),
  .word       (word)
);
